// File: src/wfgdd_pkg.sv
// ----------------------------------------------------------------------------
// Wait-for-graph deadlock detector package
// Request codes, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
package wfgdd_pkg;

  // Request kinds carried on the input tuser lane.
  typedef enum logic [1:0] {
    ACT_WAIT  = 2'd0,
    ACT_HOLD  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_CHECK = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_HOP_ROW,
    ST_HOP_COL,
    ST_FREE_ROW,
    ST_FREE_COL,
    ST_FREE_EMIT,
    ST_NONE
  } state_t;

  // Width of the process and resource fields on the ports.
  localparam int FIELD_W = 3;

  // At most this many holds are released by a single check.
  localparam int MAX_FREED = 8;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] victim;
    logic [FIELD_W-1:0] freed;
    logic               valid;
    logic               last;
  } result_t;

endpackage

// File: src/wfgdd_lowest.sv
// ----------------------------------------------------------------------------
// Lowest set bit finder
// Priority encoder that returns the index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module wfgdd_lowest #(
  parameter int N = 8
) (
  input  logic [N-1:0]                        vec,
  output logic                                found,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

// File: src/wait_for_graph_deadlock_detector.sv
// ----------------------------------------------------------------------------
// Wait-for-graph deadlock detector
// Claim table of processes against resources with an iterative cycle check.
// ----------------------------------------------------------------------------
// The block keeps, for PROCS processes and PROCS resources, whether each
// process waits for or holds each resource. An update word (wait, hold or
// clear) rewrites a row and a column and gives no result; an update whose
// process or resource index is PROCS or more is dropped. A check word walks
// the wait-for chain from every start process, lowest first: each hop takes
// the lowest resource the current process waits for and then the lowest
// process holding it. A walk that comes back to its start preempts that
// process: up to eight of its holds are released, lowest resource first,
// with one result word each. A check that finds no cycle gives a single
// word with every field zero and tlast set. The table lives in two simple
// dual-port memories, one row per process (wait and hold bits) and one
// column per resource (hold bits), with one valid bit per row and column so
// that reset clears the table at once. One priority encoder is shared by the
// hops and releases. Each hop is a row read then a column read; each release
// is a column read then a column write, held while the output stalls. The
// input is not ready while a word is in progress; a finished result waits in
// the output register without blocking the next input word.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector #(
  parameter int PROCS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input words.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] process_index, [5:3] resource_index
  input  logic [1:0] in_tuser,   // [1:0] action
  // Result words.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] victim_process, [5:3] freed_resource
  output logic [1:0] out_tuser,  // [0] deadlock_found, [1] freed_valid
  output logic       out_tlast   // last
);

  import wfgdd_pkg::*;

  localparam int IW = $clog2(PROCS);
  localparam int XW = (IW > FIELD_W) ? IW : FIELD_W;

  // Input field decode.
  logic [FIELD_W-1:0] fld_p;
  logic [FIELD_W-1:0] fld_r;
  logic [XW-1:0]      p_ext;
  logic [XW-1:0]      r_ext;
  logic [IW-1:0]      p_idx;
  logic [IW-1:0]      r_idx;
  logic               in_range;
  logic               in_fire;
  action_t            in_act;

  assign fld_p    = in_tdata[FIELD_W-1:0];
  assign fld_r    = in_tdata[2*FIELD_W-1:FIELD_W];
  assign p_ext    = XW'(fld_p);
  assign r_ext    = XW'(fld_r);
  assign p_idx    = p_ext[IW-1:0];
  assign r_idx    = r_ext[IW-1:0];
  assign in_range = (32'(fld_p) < 32'(PROCS)) && (32'(fld_r) < 32'(PROCS));
  assign in_act   = action_t'(in_tuser);

  // Sequencer state.
  state_t             state_r, state_nxt;
  logic [IW-1:0]      s_r, s_nxt;         // current start process
  logic [IW-1:0]      hop_r, hop_nxt;     // hops taken in the current walk
  logic [PROCS-1:0]   hmask_r, hmask_nxt; // victim holds not yet released
  logic [PROCS-1:0]   wkeep_r, wkeep_nxt; // victim wait bits, written back as is
  logic [2:0]         cnt_r, cnt_nxt;     // results given by this check
  logic [IW-1:0]      upd_p_r;
  logic [IW-1:0]      upd_r_r;
  action_t            upd_act_r;

  // Row memory: [PROCS-1:0] wait bits, [2*PROCS-1:PROCS] hold bits.
  logic [2*PROCS-1:0] row_mem [PROCS];
  logic [PROCS-1:0]   row_vld_r;
  logic [2*PROCS-1:0] row_rdata_r;
  logic               row_rvld_r;
  logic [2*PROCS-1:0] row_data;
  logic [IW-1:0]      row_raddr;
  logic               row_we;
  logic [IW-1:0]      row_waddr;
  logic [2*PROCS-1:0] row_wdata;

  // Column memory: bit k set when process k holds the resource.
  logic [PROCS-1:0]   col_mem [PROCS];
  logic [PROCS-1:0]   col_vld_r;
  logic [PROCS-1:0]   col_rdata_r;
  logic               col_rvld_r;
  logic [PROCS-1:0]   col_data;
  logic [IW-1:0]      col_raddr;
  logic               col_we;
  logic [IW-1:0]      col_waddr;
  logic [PROCS-1:0]   col_wdata;

  // Shared priority encoder.
  logic [PROCS-1:0]   enc_vec;
  logic               enc_found;
  logic [IW-1:0]      enc_idx;

  // Output register.
  logic               out_valid_r;
  result_t            res_r;
  result_t            res;
  logic               out_load;
  logic               slot_free;

  // Scratch values of the sequencer.
  logic [PROCS-1:0]   wait_bits;
  logic [PROCS-1:0]   hold_bits;
  logic [PROCS-1:0]   col_bits;
  logic [PROCS-1:0]   rest;
  logic               last_f;
  logic               go_next;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // An entry that was never written since reset reads as no claim.
  assign row_data = row_rvld_r ? row_rdata_r : '0;
  assign col_data = col_rvld_r ? col_rdata_r : '0;

  wfgdd_lowest #(
    .N (PROCS)
  ) u_lowest (
    .vec   (enc_vec),
    .found (enc_found),
    .idx   (enc_idx)
  );

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rdata_r <= row_mem[row_raddr];
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rdata_r <= col_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      col_vld_r  <= '0;
      row_rvld_r <= 1'b0;
      col_rvld_r <= 1'b0;
    end else begin
      if (row_we) begin
        row_vld_r[row_waddr] <= 1'b1;
      end
      if (col_we) begin
        col_vld_r[col_waddr] <= 1'b1;
      end
      row_rvld_r <= row_vld_r[row_raddr];
      col_rvld_r <= col_vld_r[col_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s_r     <= '0;
      hop_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
      hop_r   <= hop_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hmask_r <= hmask_nxt;
    wkeep_r <= wkeep_nxt;
    if (in_fire) begin
      upd_p_r   <= p_idx;
      upd_r_r   <= r_idx;
      upd_act_r <= in_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res;
    end
  end

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    hop_nxt   = hop_r;
    hmask_nxt = hmask_r;
    wkeep_nxt = wkeep_r;
    cnt_nxt   = cnt_r;
    row_raddr = s_r;
    col_raddr = '0;
    row_we    = 1'b0;
    row_waddr = s_r;
    row_wdata = '0;
    col_we    = 1'b0;
    col_waddr = '0;
    col_wdata = '0;
    out_load  = 1'b0;
    res       = '0;
    enc_vec   = '0;
    wait_bits = row_data[PROCS-1:0];
    hold_bits = row_data[2*PROCS-1:PROCS];
    col_bits  = col_data;
    rest      = hmask_r;
    last_f    = 1'b0;
    go_next   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_act == ACT_CHECK) begin
            s_nxt     = '0;
            hop_nxt   = '0;
            row_raddr = '0;
            state_nxt = ST_HOP_ROW;
          end else if (in_range) begin
            row_raddr = p_idx;
            col_raddr = r_idx;
            state_nxt = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        // Read-modify-write of one row and one column of the table.
        wait_bits[upd_r_r] = (upd_act_r == ACT_WAIT);
        hold_bits[upd_r_r] = (upd_act_r == ACT_HOLD);
        col_bits[upd_p_r]  = (upd_act_r == ACT_HOLD);
        row_we    = 1'b1;
        row_waddr = upd_p_r;
        row_wdata = {hold_bits, wait_bits};
        col_we    = 1'b1;
        col_waddr = upd_r_r;
        col_wdata = col_bits;
        state_nxt = ST_IDLE;
      end

      ST_HOP_ROW: begin
        enc_vec = wait_bits;
        if (!enc_found) begin
          go_next = 1'b1;
        end else begin
          col_raddr = enc_idx;
          state_nxt = ST_HOP_COL;
        end
      end

      ST_HOP_COL: begin
        enc_vec = col_bits;
        if (!enc_found) begin
          go_next = 1'b1;
        end else if (enc_idx == s_r) begin
          row_raddr = s_r;
          state_nxt = ST_FREE_ROW;
        end else if (hop_r == IW'(PROCS - 1)) begin
          go_next = 1'b1;
        end else begin
          hop_nxt   = hop_r + 1'b1;
          row_raddr = enc_idx;
          state_nxt = ST_HOP_ROW;
        end
      end

      ST_FREE_ROW: begin
        hmask_nxt = hold_bits;
        wkeep_nxt = wait_bits;
        cnt_nxt   = '0;
        state_nxt = ST_FREE_COL;
      end

      ST_FREE_COL: begin
        enc_vec   = hmask_r;
        col_raddr = enc_idx;
        state_nxt = ST_FREE_EMIT;
      end

      ST_FREE_EMIT: begin
        enc_vec   = hmask_r;
        col_raddr = enc_idx;
        if (slot_free) begin
          rest[enc_idx]  = 1'b0;
          col_bits[s_r]  = 1'b0;
          last_f         = (rest == '0) || (cnt_r == 3'(MAX_FREED - 1));
          col_we         = 1'b1;
          col_waddr      = enc_idx;
          col_wdata      = col_bits;
          out_load       = 1'b1;
          res.found      = 1'b1;
          res.victim     = FIELD_W'(s_r);
          res.freed      = FIELD_W'(enc_idx);
          res.valid      = 1'b1;
          res.last       = last_f;
          hmask_nxt      = rest;
          cnt_nxt        = cnt_r + 1'b1;
          if (last_f) begin
            // Holds beyond the release limit stay in the row.
            row_we    = 1'b1;
            row_waddr = s_r;
            row_wdata = {rest, wkeep_r};
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FREE_COL;
          end
        end
      end

      ST_NONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          res.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The walk from this start ended without a cycle: move to the next start.
    if (go_next) begin
      if (s_r == IW'(PROCS - 1)) begin
        state_nxt = ST_NONE;
      end else begin
        s_nxt     = s_r + 1'b1;
        hop_nxt   = '0;
        row_raddr = s_r + 1'b1;
        state_nxt = ST_HOP_ROW;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.freed, res_r.victim};
  assign out_tuser  = {res_r.valid, res_r.found};
  assign out_tlast  = res_r.last;

endmodule

// File: src/wfgdd_checker.sv
// ----------------------------------------------------------------------------
// Wait-for-graph deadlock detector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wfgdd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  import wfgdd_pkg::*;

  // A result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word dropped or changed while stalled");

  // A check keeps the input closed on the following cycle.
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_CHECK |=> !in_tready)
    else $error("input accepted right after a check");

  // A check without a cycle gives one empty, final word.
  a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && !out_tuser[1] && out_tdata == 8'd0)
    else $error("no-deadlock result is not a single empty word");

  // Every deadlock result names a released resource.
  a_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("deadlock result without a released resource");

endmodule

bind wait_for_graph_deadlock_detector wfgdd_checker u_wfgdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb_wait_for_graph_deadlock_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the wait-for-graph deadlock detector
// Streams claim updates and deadlock checks into the block with bursty input
// and a stalling receiver. It keeps its own copy of the claim table, works out
// every result word a check must give, and compares each received word field
// by field, in order.
// ----------------------------------------------------------------------------
module tb_wait_for_graph_deadlock_detector;
  import wfgdd_pkg::*;

  localparam int PROCS = 8;
  // A check walks at most PROCS*PROCS hops, then frees up to eight holds; this
  // tail covers that with room to spare.
  localparam int TAIL_CYCLES = 400;
  // Worst case is every check at its longest, every result word held by the
  // slowest receiver pattern, plus the long hold-off. Several times over.
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLDOFF_AT = 150;
  localparam int HOLDOFF_LEN = 400;
  localparam int RANDOM_WORDS = 345;

  // Per-entry claim state, as the block keeps it.
  typedef enum logic [1:0] {
    CL_NONE = 2'd0,
    CL_WAIT = 2'd1,
    CL_HOLD = 2'd2
  } claim_t;

  // One input word before packing onto the bus.
  typedef struct packed {
    action_t    act;
    logic [2:0] proc;
    logic [2:0] res;
  } claim_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;   // [2:0] process_index, [5:3] resource_index
  logic [1:0] in_tuser = 2'd0;   // [1:0] action
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [2:0] victim_process, [5:3] freed_resource
  logic [1:0] out_tuser;         // [0] deadlock_found, [1] freed_valid
  logic       out_tlast;

  // Words still to be sent, and the result words the table model says are due.
  claim_req_t req_words[$];
  result_t    due_results[$];

  // The model's copy of the claim table.
  claim_t claims [PROCS][PROCS];

  int total_words = 0;
  int words_accepted = 0;
  int checks_run = 0;
  int victims_seen = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;

  wait_for_graph_deadlock_detector #(
    .PROCS(PROCS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // Follows the wait-for chain from one start process. Each hop takes the
  // lowest resource the current process waits for, then the lowest holder of
  // that resource. The walk gives up after PROCS hops, so a cycle that does not
  // pass through the start cannot trap it.
  function automatic bit chain_closes(int start);
    int cur;
    int want_res;
    int holder;
    cur = start;
    for (int hop = 0; hop < PROCS; hop++) begin
      want_res = PROCS;
      for (int j = PROCS - 1; j >= 0; j--)
        if (claims[cur][j] == CL_WAIT) want_res = j;
      if (want_res == PROCS) return 1'b0;
      holder = PROCS;
      for (int k = PROCS - 1; k >= 0; k--)
        if (claims[k][want_res] == CL_HOLD) holder = k;
      if (holder == PROCS) return 1'b0;
      if (holder == start) return 1'b1;
      cur = holder;
    end
    return 1'b0;
  endfunction

  // Applies one accepted word to the table copy. A check picks the lowest
  // process whose walk closes, releases all of its holds (lowest resource
  // first) and queues one result word per release; otherwise it queues a
  // single all-zero word with last set.
  function automatic void track_claims(claim_req_t w);
    result_t rw;
    int victim;
    int hold_cnt;
    int emitted;
    if (w.act != ACT_CHECK) begin
      case (w.act)
        ACT_WAIT: claims[w.proc][w.res] = CL_WAIT;
        ACT_HOLD: claims[w.proc][w.res] = CL_HOLD;
        default:  claims[w.proc][w.res] = CL_NONE;
      endcase
      return;
    end
    checks_run++;
    victim = -1;
    for (int s = 0; s < PROCS; s++)
      if (victim < 0 && chain_closes(s)) victim = s;
    hold_cnt = 0;
    if (victim >= 0)
      for (int j = 0; j < PROCS; j++)
        if (claims[victim][j] == CL_HOLD) hold_cnt++;
    if (hold_cnt == 0) begin
      rw = '{found: 1'b0, victim: '0, freed: '0, valid: 1'b0, last: 1'b1};
      due_results.push_back(rw);
      return;
    end
    victims_seen++;
    emitted = 0;
    for (int j = 0; j < PROCS; j++) begin
      if (claims[victim][j] == CL_HOLD) begin
        claims[victim][j] = CL_NONE;
        emitted++;
        rw.found  = 1'b1;
        rw.victim = victim[2:0];
        rw.freed  = j[2:0];
        rw.valid  = 1'b1;
        rw.last   = (emitted == hold_cnt);
        due_results.push_back(rw);
      end
    end
  endfunction

  task automatic queue_word(action_t a, logic [2:0] p, logic [2:0] r);
    claim_req_t w;
    w.act  = a;
    w.proc = p;
    w.res  = r;
    req_words.push_back(w);
  endtask

  // Builds a ring of distinct processes, each holding one resource and waiting
  // for the resource the next one holds, then asks for a check. Sometimes the
  // first process gets extra holds so that one check frees several resources,
  // and sometimes one wait is left out so the ring stays open.
  task automatic plant_cycle();
    int procs[PROCS];
    int ress[PROCS];
    int len;
    int tmp;
    int pick;
    int skip;
    for (int i = 0; i < PROCS; i++) begin
      procs[i] = i;
      ress[i] = i;
    end
    for (int i = PROCS - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = procs[i]; procs[i] = procs[pick]; procs[pick] = tmp;
      pick = $urandom_range(0, i);
      tmp = ress[i]; ress[i] = ress[pick]; ress[pick] = tmp;
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(2, 4);
    skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      queue_word(ACT_HOLD, 3'(procs[i]), 3'(ress[i]));
      if (i != skip) queue_word(ACT_WAIT, 3'(procs[i]), 3'(ress[(i + 1) % len]));
      if ($urandom_range(0, 5) == 0)
        queue_word(action_t'(2'($urandom_range(0, 2))), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
    end
    for (int i = $urandom_range(0, 3); i > 0; i--)
      queue_word(ACT_HOLD, 3'(procs[0]),
                 3'(ress[$urandom_range(len - 1 < PROCS - 1 ? len : 0, PROCS - 1)]));
    queue_word(ACT_CHECK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    int pick;
    for (int p = 0; p < PROCS; p++)
      for (int r = 0; r < PROCS; r++)
        claims[p][r] = CL_NONE;

    // Directed part. A check on the empty table, then extreme indexes with no
    // cycle, then a walk from process 0 that runs into a ring of 6 and 7 which
    // does not contain it (the cap must end it and 6 becomes the victim), a
    // repeat check after the preemption, clears at the extremes, and finally a
    // victim that holds seven resources at once.
    queue_word(ACT_CHECK, 3'd0, 3'd0);
    queue_word(ACT_WAIT, 3'd7, 3'd7);
    queue_word(ACT_HOLD, 3'd0, 3'd0);
    queue_word(ACT_CHECK, 3'd7, 3'd7);
    queue_word(ACT_HOLD, 3'd6, 3'd7);
    queue_word(ACT_WAIT, 3'd6, 3'd1);
    queue_word(ACT_HOLD, 3'd7, 3'd1);
    queue_word(ACT_WAIT, 3'd0, 3'd7);
    queue_word(ACT_HOLD, 3'd6, 3'd0);
    queue_word(ACT_CHECK, 3'd5, 3'd2);
    queue_word(ACT_CHECK, 3'd0, 3'd0);
    queue_word(ACT_CLEAR, 3'd7, 3'd7);
    queue_word(ACT_CLEAR, 3'd0, 3'd7);
    queue_word(ACT_CLEAR, 3'd0, 3'd0);
    for (int r = 0; r < 7; r++) queue_word(ACT_HOLD, 3'd4, 3'(r));
    queue_word(ACT_WAIT, 3'd4, 3'd7);
    queue_word(ACT_HOLD, 3'd5, 3'd7);
    queue_word(ACT_WAIT, 3'd5, 3'd0);
    queue_word(ACT_CHECK, 3'd7, 3'd7);

    // Random part: mostly planted rings with random content, the rest lone
    // checks and loose updates that both feed and break up the table.
    while (req_words.size() < RANDOM_WORDS + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        plant_cycle();
      else if (pick < 45)
        queue_word(ACT_CHECK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      else
        queue_word(action_t'(2'($urandom_range(0, 2))), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
    end
    total_words = req_words.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted != total_words) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words including %0d checks; %0d checks preempted a victim.",
             total_words, checks_run, victims_seen);
    $display("Received %0d result words; %0d field mismatches or stray words.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Sender. A word is handed to the table model at the edge where it is taken.
  // The sender runs in bursts of random length with random gaps, and about a
  // third of the bursts follow on with no gap at all.
  int burst_left = 0;
  int gap_left = 0;
  claim_req_t cur_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        track_claims(cur_word);
        words_accepted <= words_accepted + 1;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (req_words.size() != 0) begin
        cur_word = req_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, cur_word.res, cur_word.proc};
        in_tuser  <= cur_word.act;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. It rotates an 8-bit ready pattern that is redrawn when its epoch
  // count runs out, sometimes as always-ready. Once, after enough words have
  // gone in, it holds off for a long stretch so that a finished result sits in
  // the output register and the next check backs up into the input.
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int stall_epoch = 0;
  logic [7:0] stall_pat = 8'hFF;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else if (!holdoff_done && words_accepted >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      out_tready <= 1'b0;
    end else begin
      if (stall_epoch == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                : (8'($urandom_range(0, 255)) | 8'h01);
        stall_epoch = 48;
      end else begin
        stall_epoch--;
      end
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      out_tready <= stall_pat[0];
    end
  end

  // Result checker: every taken result word against the oldest due one.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result word with nothing due: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_tuser[0] !== want.found) begin
          $error("deadlock_found: expected %0d, got %0d", want.found, out_tuser[0]);
          mismatches++;
        end
        if (out_tdata[2:0] !== want.victim) begin
          $error("victim_process: expected %0d, got %0d", want.victim, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[5:3] !== want.freed) begin
          $error("freed_resource: expected %0d, got %0d", want.freed, out_tdata[5:3]);
          mismatches++;
        end
        if (out_tuser[1] !== want.valid) begin
          $error("freed_valid: expected %0d, got %0d", want.valid, out_tuser[1]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d words taken, %0d results due.",
               cycle_count, words_accepted, total_words, due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// File: wait_for_graph_deadlock_detector.f
src/wfgdd_pkg.sv
src/wfgdd_lowest.sv
src/wait_for_graph_deadlock_detector.sv
src/wfgdd_checker.sv
tb/tb_wait_for_graph_deadlock_detector.sv
